// File: src/prtx_pkg.sv
package prtx_pkg;

   localparam int DEPTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_FETCH = 2'd1,
      OP_TICK  = 2'd2,
      OP_FAIL  = 2'd3
   } op_type;

   localparam logic [2:0] ACT_STORED    = 3'd0;
   localparam logic [2:0] ACT_DUPLICATE = 3'd1;
   localparam logic [2:0] ACT_FULL      = 3'd2;
   localparam logic [2:0] ACT_FETCHED   = 3'd3;
   localparam logic [2:0] ACT_NOT_FOUND = 3'd4;
   localparam logic [2:0] ACT_EXPIRED   = 3'd5;
   localparam logic [2:0] ACT_REQUEUE   = 3'd6;
   localparam logic [2:0] ACT_DROPPED   = 3'd7;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [31:0] saved_id;
      logic [15:0] request_tag;
      logic        has_deadline;
      logic [31:0] deadline;
      logic        routable;
      logic [31:0] now_time;
   } item_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] saved;
      logic [31:0] deadline;
      logic [31:0] age;
      logic [15:0] tag;
      logic        timed;
      logic        route;
   } entry_type;

endpackage

// File: src/prtx_front.sv
module prtx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [31:0]         req_key,
   input  logic [31:0]         req_saved_id,
   input  logic [15:0]         req_request_tag,
   input  logic                req_has_deadline,
   input  logic [31:0]         req_deadline,
   input  logic                req_routable,
   input  logic [31:0]         req_now_time,
   output logic                item_valid,
   output prtx_pkg::item_type  item,
   input  logic                item_pop
);

   logic [1:0]         count_ff;
   prtx_pkg::item_type slot0_ff;
   prtx_pkg::item_type slot1_ff;
   prtx_pkg::item_type new_item;
   logic               push;
   logic               pop;

   always_comb begin
      new_item.op           = prtx_pkg::op_type'(req_op);
      new_item.key          = req_key;
      new_item.saved_id     = req_saved_id;
      new_item.request_tag  = req_request_tag;
      new_item.has_deadline = req_has_deadline;
      new_item.deadline     = req_deadline;
      new_item.routable     = req_routable;
      new_item.now_time     = req_now_time;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && (count_ff != 2'd0);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            slot0_ff <= slot1_ff;
         end else begin
            slot0_ff <= new_item;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= new_item;
         end else begin
            slot1_ff <= new_item;
         end
      end
   end

endmodule

// File: src/prtx_engine.sv
module prtx_engine #(
   parameter int DEPTH = prtx_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  prtx_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_action,
   output logic [15:0]        rsp_out_tag,
   output logic [31:0]        rsp_restored_id,
   output logic               rsp_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type           state_ff;
   prtx_pkg::item_type  cur_ff;
   prtx_pkg::entry_type mem [DEPTH];
   prtx_pkg::entry_type rd_ff;
   logic [IW-1:0]       rd_idx_ff;
   logic                rd_vld_ff;
   logic                rd_last_ff;
   logic [IW-1:0]       iss_cnt_ff;
   logic                iss_act_ff;
   logic [DEPTH-1:0]    valid_ff;
   logic [31:0]         age_ff;
   logic                best_ff;
   logic [IW-1:0]       best_idx_ff;
   prtx_pkg::entry_type best_ent_ff;
   logic [CW-1:0]       cnt_ff;
   logic                out_vld_ff;
   logic [2:0]          out_action_ff;
   logic [15:0]         out_tag_ff;
   logic [31:0]         out_id_ff;
   logic                out_last_ff;

   logic                qual;
   logic                better;
   logic                full;
   logic [IW-1:0]       free_idx;
   logic                out_free;
   logic                mem_we;
   logic                emit_go;
   prtx_pkg::entry_type mem_wd;

   assign item_pop = (state_ff == ST_IDLE) && item_valid;
   assign out_free = !out_vld_ff || !rsp_stall;
   assign full     = &valid_ff;
   // a result enters the output register this cycle
   assign emit_go  = (state_ff == ST_EMIT) && out_free &&
                     (best_ff || (cur_ff.op == prtx_pkg::OP_STORE) ||
                      (cur_ff.op == prtx_pkg::OP_FETCH));

   always_comb begin
      free_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   // compare stage: one entry per cycle against the best seen so far
   always_comb begin
      qual   = 1'b0;
      better = 1'b0;
      unique case (cur_ff.op)
         prtx_pkg::OP_STORE, prtx_pkg::OP_FETCH: begin
            qual   = valid_ff[rd_idx_ff] && (rd_ff.key == cur_ff.key);
            better = !best_ff;
         end
         prtx_pkg::OP_TICK: begin
            qual   = valid_ff[rd_idx_ff] && rd_ff.timed && (rd_ff.deadline <= cur_ff.now_time);
            // newest first on equal deadlines
            better = !best_ff || (rd_ff.deadline < best_ent_ff.deadline) ||
                     ((rd_ff.deadline == best_ent_ff.deadline) &&
                      ((age_ff - rd_ff.age) < (age_ff - best_ent_ff.age)));
         end
         prtx_pkg::OP_FAIL: begin
            qual   = valid_ff[rd_idx_ff];
            better = !best_ff || (rd_ff.key < best_ent_ff.key);
         end
         default: begin
            qual   = 1'b0;
            better = 1'b0;
         end
      endcase
   end

   always_comb begin
      mem_we          = (state_ff == ST_EMIT) && out_free && (cur_ff.op == prtx_pkg::OP_STORE)
                        && !best_ff && !full;
      mem_wd.key      = cur_ff.key;
      mem_wd.saved    = cur_ff.saved_id;
      mem_wd.deadline = cur_ff.has_deadline ? cur_ff.deadline : 32'd0;
      mem_wd.age      = age_ff;
      mem_wd.tag      = cur_ff.request_tag;
      mem_wd.timed    = cur_ff.has_deadline;
      mem_wd.route    = cur_ff.routable;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx] <= mem_wd;
      end
      rd_ff <= mem[iss_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && item_valid) begin
         cur_ff <= item;
      end
      rd_idx_ff  <= iss_cnt_ff;
      rd_last_ff <= (iss_cnt_ff == IW'(DEPTH - 1));
      if (state_ff == ST_SCAN) begin
         if (rd_vld_ff && qual) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (better) begin
               best_ff     <= 1'b1;
               best_idx_ff <= rd_idx_ff;
               best_ent_ff <= rd_ff;
            end
         end
      end else if (state_ff == ST_IDLE || out_free) begin
         // a stalled emit keeps its pick
         best_ff <= 1'b0;
         cnt_ff  <= '0;
      end
      if (state_ff == ST_EMIT && out_free) begin
         out_id_ff  <= 32'd0;
         out_last_ff <= 1'b1;
         unique case (cur_ff.op)
            prtx_pkg::OP_STORE: begin
               out_tag_ff    <= cur_ff.request_tag;
               out_action_ff <= best_ff ? prtx_pkg::ACT_DUPLICATE :
                                full    ? prtx_pkg::ACT_FULL : prtx_pkg::ACT_STORED;
            end
            prtx_pkg::OP_FETCH: begin
               out_action_ff <= best_ff ? prtx_pkg::ACT_FETCHED : prtx_pkg::ACT_NOT_FOUND;
               out_tag_ff    <= best_ff ? best_ent_ff.tag : 16'd0;
               out_id_ff     <= best_ff ? best_ent_ff.saved : 32'd0;
            end
            prtx_pkg::OP_TICK: begin
               out_action_ff <= prtx_pkg::ACT_EXPIRED;
               out_tag_ff    <= best_ent_ff.tag;
               out_last_ff   <= (cnt_ff == CW'(1));
            end
            prtx_pkg::OP_FAIL: begin
               out_action_ff <= best_ent_ff.route ? prtx_pkg::ACT_REQUEUE : prtx_pkg::ACT_DROPPED;
               out_tag_ff    <= best_ent_ff.tag;
               out_last_ff   <= (cnt_ff == CW'(1));
            end
            default: begin
               out_action_ff <= prtx_pkg::ACT_STORED;
               out_tag_ff    <= 16'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         age_ff     <= 32'd0;
         out_vld_ff <= 1'b0;
         iss_act_ff <= 1'b0;
         iss_cnt_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         out_vld_ff <= emit_go || (out_vld_ff && rsp_stall);
         rd_vld_ff <= iss_act_ff;
         if (iss_act_ff) begin
            iss_cnt_ff <= iss_cnt_ff + IW'(1);
            if (iss_cnt_ff == IW'(DEPTH - 1)) begin
               iss_act_ff <= 1'b0;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  iss_cnt_ff <= '0;
                  iss_act_ff <= 1'b1;
                  state_ff   <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_vld_ff && rd_last_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  unique case (cur_ff.op)
                     prtx_pkg::OP_STORE: begin
                        state_ff   <= ST_IDLE;
                        if (mem_we) begin
                           valid_ff[free_idx] <= 1'b1;
                           age_ff             <= age_ff + 32'd1;
                        end
                     end
                     prtx_pkg::OP_FETCH: begin
                        state_ff   <= ST_IDLE;
                        if (best_ff) begin
                           valid_ff[best_idx_ff] <= 1'b0;
                        end
                     end
                     prtx_pkg::OP_TICK, prtx_pkg::OP_FAIL: begin
                        if (best_ff) begin
                           valid_ff[best_idx_ff] <= 1'b0;
                           if (cnt_ff == CW'(1)) begin
                              state_ff <= ST_IDLE;
                           end else begin
                              // another pass for the next entry in order
                              iss_cnt_ff <= '0;
                              iss_act_ff <= 1'b1;
                              state_ff   <= ST_SCAN;
                           end
                        end else begin
                           state_ff <= ST_IDLE;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_action      = out_action_ff;
   assign rsp_out_tag     = out_tag_ff;
   assign rsp_restored_id = out_id_ff;
   assign rsp_last        = out_last_ff;

endmodule

// File: src/pending_request_table_with_expiry_top.sv
// Pending request table: holds up to DEPTH outstanding requests keyed by a 32-bit id.
// A two-item input queue takes requests while the table engine works. Each pass of the
// engine reads the entry memory once per cycle through its single read port, walking
// every entry. Store and fetch take one pass. A tick or failover that reports n entries
// takes n passes (one pass when nothing is reported), since each pass picks the next
// entry in deadline or key order. A result sits in an output register, so the engine
// carries on while the consumer stalls, until the next result is ready.
module pending_request_table_with_expiry_top #(
   parameter int DEPTH = prtx_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_key,
   input  logic [31:0] req_saved_id,
   input  logic [15:0] req_request_tag,
   input  logic        req_has_deadline,
   input  logic [31:0] req_deadline,
   input  logic        req_routable,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [15:0] rsp_out_tag,
   output logic [31:0] rsp_restored_id,
   output logic        rsp_last
);

   logic               item_valid;
   logic               item_pop;
   prtx_pkg::item_type item;

   prtx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_key          (req_key),
      .req_saved_id     (req_saved_id),
      .req_request_tag  (req_request_tag),
      .req_has_deadline (req_has_deadline),
      .req_deadline     (req_deadline),
      .req_routable     (req_routable),
      .req_now_time     (req_now_time),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   prtx_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_restored_id (rsp_restored_id),
      .rsp_last        (rsp_last)
   );

endmodule
